@@ rtl/core/chained_hash_map_engine_assert.svh @@
// Assertion macros for the hash map engine
`ifndef CHAINED_HASH_MAP_ENGINE_ASSERT_SVH
`define CHAINED_HASH_MAP_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define CHM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CHM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CHM_ASSERT(lbl, clk, rst_n, prop, msg)
`define CHM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/core/chm_pkg.sv @@
`timescale 1ns / 1ps
package chm_pkg;

  typedef enum logic [2:0] {
    KIND_LOOKUP  = 3'd0,
    KIND_ADD     = 3'd1,
    KIND_ADD_REP = 3'd2,
    KIND_REMOVE  = 3'd3,
    KIND_CLEAR   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_HEAD_RD,
    S_HEAD_WT,
    S_ENT_WT,
    S_CHECK,
    S_ADD_ALLOC,
    S_ADD_WR,
    S_UNLINK,
    S_OUT
  } fsm_e;

  localparam int KeyW     = 64;
  localparam int CountW   = 11;
  localparam int HashCfgW = 4;
  localparam int HashShift = 8;
  localparam logic [HashCfgW-1:0] HashReset = 4'd8;

endpackage

@@ rtl/core/chained_hash_map_engine.sv @@
`timescale 1ns / 1ps
// Separate-chaining hash map over a fixed entry pool. Each item is one
// operation (lookup, add, add-or-replace, remove, clear) and gives one
// result; the next item is taken once that result has been transferred.
// The chain walk reads one entry at a time from the entry memory
// (address, registered read), up to the hit or the null end. A remove
// that hits adds an unlink step, an add-or-replace that misses adds an
// allocate and a write step, and a plain add allocates and writes
// without walking the chain; an unused kind touches nothing. A write of
// the bucket width register empties the table as a clear does; after
// reset, after a clear and after such a write, a clearing pass writes
// null to every bucket head, one per cycle, before the next item is
// taken.
`include "chained_hash_map_engine_assert.svh"
module chained_hash_map_engine import chm_pkg::*; #(
  parameter int MAX_BUCKET_BITS = 10,
  parameter int POOL_ENTRIES    = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [HashCfgW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          kind_i,
  input  logic [KeyW-1:0]     key_i,
  input  logic [KeyW-1:0]     value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [KeyW-1:0]     payload_o,
  output logic [CountW-1:0]   entry_count_o
);
  localparam int IdxW = $clog2(POOL_ENTRIES);
  localparam int LnkW = IdxW + 1;
  localparam int BktW = MAX_BUCKET_BITS;
  localparam int NBkt = 1 << MAX_BUCKET_BITS;
  localparam logic [LnkW-1:0] NullLink = LnkW'(POOL_ENTRIES);

  logic [LnkW-1:0] head_mem [NBkt];
  logic [KeyW-1:0] key_mem  [POOL_ENTRIES];
  logic [KeyW-1:0] pay_mem  [POOL_ENTRIES];
  logic [LnkW-1:0] link_mem [POOL_ENTRIES];
  logic [IdxW-1:0] free_mem [POOL_ENTRIES];

  fsm_e state_q, state_d;
  logic [HashCfgW-1:0] hbits_q;
  logic [BktW-1:0] sweep_q;
  logic [2:0] kind_q;
  logic [KeyW-1:0] key_q, val_q;
  logic [BktW-1:0] bkt_q;
  logic [LnkW-1:0] cur_q, prev_q;
  logic [LnkW:0] steps_q;
  logic [LnkW-1:0] free_depth_q, fresh_q;
  logic [LnkW-1:0] live_q;
  logic [IdxW-1:0] alloc_q;
  logic alloc_ok_q;
  logic out_valid_q;
  logic [1:0] status_q;
  logic [KeyW-1:0] payload_q;

  logic [LnkW-1:0] head_rd_q, link_rd_q;
  logic [KeyW-1:0] key_rd_q, pay_rd_q;
  logic [IdxW-1:0] free_rd_q;

  logic [BktW-1:0] bkt_mask, bkt_in;
  logic [KeyW-1:0] hx;
  logic [HashCfgW-1:0] hb_sat;
  logic accept;

  always_comb begin
    hb_sat = (int'(hbits_q) > MAX_BUCKET_BITS) ? HashCfgW'(MAX_BUCKET_BITS) : hbits_q;
    bkt_mask = BktW'((({{(KeyW-1){1'b0}}, 1'b1}) << hb_sat) - KeyW'(1));
    hx = key_i ^ (key_i >> HashShift);
    bkt_in = BktW'(hx) & bkt_mask;
  end

  assign in_stall_o = (state_q != S_IDLE) || out_valid_q || cfg_we_i;
  assign accept = in_valid_i && !in_stall_o;

  // walk position helpers
  logic cur_live;
  logic key_hit;
  assign cur_live = (cur_q < NullLink) && (steps_q < (LnkW+1)'(POOL_ENTRIES));
  assign key_hit  = key_rd_q == key_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_SWEEP:     if (sweep_q == BktW'(NBkt-1)) state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (kind_i)
            KIND_LOOKUP, KIND_ADD_REP, KIND_REMOVE: state_d = S_HEAD_RD;
            KIND_ADD:   state_d = S_ADD_ALLOC;
            KIND_CLEAR: state_d = S_SWEEP;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_HEAD_RD:   state_d = S_HEAD_WT;
      S_HEAD_WT:   state_d = S_ENT_WT;
      S_ENT_WT:    state_d = S_CHECK;
      S_CHECK: begin
        if (!cur_live) state_d = (kind_q == KIND_ADD_REP) ? S_ADD_ALLOC : S_OUT;
        else if (key_hit) state_d = (kind_q == KIND_REMOVE) ? S_UNLINK : S_OUT;
        else state_d = S_ENT_WT;
      end
      S_ADD_ALLOC: state_d = S_ADD_WR;
      S_ADD_WR:    state_d = S_OUT;
      S_UNLINK:    state_d = S_OUT;
      S_OUT:       state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
    // a register write restarts the clearing pass from any state
    if (cfg_we_i) state_d = S_SWEEP;
  end

  // memories: head read address is the bucket, entry read address is cur
  logic [IdxW-1:0] ent_addr;
  assign ent_addr = IdxW'(cur_q);

  always_ff @(posedge clk_i) begin
    head_rd_q <= head_mem[bkt_q];
    key_rd_q  <= key_mem[ent_addr];
    pay_rd_q  <= pay_mem[ent_addr];
    link_rd_q <= link_mem[ent_addr];
    free_rd_q <= free_mem[IdxW'(free_depth_q - LnkW'(1))];
    if (state_q == S_SWEEP) head_mem[sweep_q] <= NullLink;
    else if (state_q == S_ADD_WR && alloc_ok_q) head_mem[bkt_q] <= LnkW'(alloc_q);
    else if (state_q == S_UNLINK && prev_q == NullLink) head_mem[bkt_q] <= link_rd_q;
    if (state_q == S_ADD_WR && alloc_ok_q) begin
      key_mem[alloc_q]  <= key_q;
      pay_mem[alloc_q]  <= val_q;
      link_mem[alloc_q] <= head_rd_q;
    end else if (state_q == S_CHECK && cur_live && key_hit && kind_q == KIND_ADD_REP) begin
      pay_mem[ent_addr] <= val_q;
    end else if (state_q == S_UNLINK && prev_q != NullLink) begin
      link_mem[IdxW'(prev_q)] <= link_rd_q;
    end
    if (state_q == S_UNLINK && free_depth_q < NullLink)
      free_mem[IdxW'(free_depth_q)] <= ent_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      hbits_q <= HashReset;
      sweep_q <= '0;
      free_depth_q <= '0;
      fresh_q <= '0;
      live_q <= '0;
      out_valid_q <= 1'b0;
      kind_q <= '0;
      alloc_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        hbits_q <= cfg_wdata_i;
        sweep_q <= '0;
        free_depth_q <= '0;
        fresh_q <= '0;
        live_q <= '0;
      end else begin
        case (state_q)
          S_SWEEP: sweep_q <= sweep_q + BktW'(1);
          S_IDLE: begin
            sweep_q <= '0;
            if (accept) begin
              kind_q <= kind_i;
              if (kind_i == KIND_CLEAR) begin
                free_depth_q <= '0;
                fresh_q <= '0;
                live_q <= '0;
              end
              if (kind_i == KIND_CLEAR || kind_i > KIND_CLEAR) out_valid_q <= 1'b1;
            end
          end
          S_CHECK: if (!cur_live && kind_q == KIND_ADD_REP) alloc_ok_q <= 1'b0;
          S_ADD_ALLOC: begin
            // head_rd_q settles for S_ADD_WR since bkt_q was set at accept
            if (free_depth_q != '0) begin
              alloc_ok_q <= 1'b1;
              free_depth_q <= free_depth_q - LnkW'(1);
            end else if (fresh_q < NullLink) begin
              alloc_ok_q <= 1'b1;
              fresh_q <= fresh_q + LnkW'(1);
            end else alloc_ok_q <= 1'b0;
          end
          S_ADD_WR: if (alloc_ok_q) live_q <= live_q + LnkW'(1);
          S_UNLINK: begin
            if (live_q != '0) live_q <= live_q - LnkW'(1);
            if (free_depth_q < NullLink) free_depth_q <= free_depth_q + LnkW'(1);
          end
          S_OUT: out_valid_q <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  // payload path registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (accept) begin
        key_q <= key_i;
        val_q <= value_i;
        bkt_q <= bkt_in;
        steps_q <= '0;
        prev_q <= NullLink;
        status_q <= ST_DONE;
        payload_q <= '0;
      end
      S_HEAD_WT: cur_q <= head_rd_q;
      S_CHECK: begin
        if (!cur_live) begin
          if (kind_q != KIND_ADD_REP) status_q <= ST_NOT_FOUND;
        end else if (key_hit) begin
          if (kind_q != KIND_ADD_REP) payload_q <= pay_rd_q;
        end else begin
          prev_q <= cur_q;
          cur_q <= link_rd_q;
          steps_q <= steps_q + (LnkW+1)'(1);
        end
      end
      S_ADD_ALLOC: begin
        if (free_depth_q != '0) alloc_q <= free_rd_q;
        else alloc_q <= IdxW'(fresh_q);
        if (free_depth_q == '0 && fresh_q >= NullLink) status_q <= ST_FULL;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign status_o = status_q;
  assign payload_o = payload_q;
  assign entry_count_o = CountW'(live_q);

  `CHM_ASSERT(a_no_accept_busy, clk_i, rst_ni, !(accept && state_q != S_IDLE), "accept while busy")
  `CHM_ASSERT(a_count_bound, clk_i, rst_ni, live_q <= LnkW'(POOL_ENTRIES), "count overflow")
  `CHM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && out_stall_i, out_valid_q, "result lost")
endmodule
